/* rtl/core/gbw_pkg.sv */
// ----------------------------------------------------------------------------
// gbw_pkg
// Shared types and constants of the 5x5 Gaussian blur window.
// ----------------------------------------------------------------------------
package gbw_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int ROW_W   = 11;
    localparam int BORDER  = 2;
    localparam int KSIZE   = 2 * BORDER + 1;
    localparam int LINES   = KSIZE - 1;
    localparam int MAX_HEIGHT = 1024;

    // weighted column sum: heaviest column is 107 * 255
    localparam int CSUM_W  = 15;
    // full window sum: at most 273 * 255
    localparam int SUM_W   = 17;

    // divide by 273 as multiply by ceil(2^26 / 273) then shift right by 26
    localparam int RECIP_W   = 18;
    localparam logic [RECIP_W-1:0] RECIP = 18'd245821;
    localparam int DIV_SHIFT = 26;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef logic [6:0] t_wgt;
    typedef logic [KSIZE-1:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_tag;

    localparam t_wgt KERNEL [KSIZE][KSIZE] = '{
        '{7'd1, 7'd4,  7'd7,  7'd4,  7'd1},
        '{7'd4, 7'd16, 7'd26, 7'd16, 7'd4},
        '{7'd7, 7'd26, 7'd41, 7'd26, 7'd7},
        '{7'd4, 7'd16, 7'd26, 7'd16, 7'd4},
        '{7'd1, 7'd4,  7'd7,  7'd4,  7'd1}
    };

endpackage

/* rtl/core/gaussian_blur_5x5_window.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_window
// Streaming 5x5 Gaussian blur (kernel sum 273) over a zero-padded frame.
// Stages: input register with line store read, column cell, column sum, total,
// product, output register. Throughput: one word per cycle; a stalled output register holds the whole
// pipeline, set by the single read and single write port of the line store.
// Reset: synchronous, clears counters and valids, width and height return to 256 (width at most MAX_WIDTH).
// The line store is not cleared; its first four rows are filled by each frame.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pix_valid,
    output logic                             o_pix_ready,
    input  logic [gbw_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [gbw_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                             o_row_end,
    output logic                             o_frame_end,
    input  logic                             i_cfg_we,
    input  logic [gbw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbw_pkg::CFG_W-1:0]        i_cfg_data
);
    import gbw_pkg::*;

    localparam int LINE_LEN  = MAX_WIDTH + 2 * BORDER;
    localparam int XW        = $clog2(LINE_LEN);
    // reset width of 256, limited to the line store
    localparam int RST_WIDTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

    // ---- control ----
    logic          w_adv;
    logic          w_accept;

    logic [XW-1:0]    r_col_last;
    logic [ROW_W-1:0] r_row_last;
    logic [XW-1:0]    r_x;
    logic [ROW_W-1:0] r_y;

    logic [CFG_W-1:0] w_wid;
    logic [CFG_W-1:0] w_hgt;

    assign w_adv       = !o_res_valid || i_res_ready;
    assign o_pix_ready = w_adv;
    assign w_accept    = i_pix_valid && w_adv;

    always_comb begin
        w_wid = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_wid = CFG_W'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            w_wid = CFG_W'(MAX_WIDTH);
        end
        w_hgt = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_hgt = CFG_W'(1);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            w_hgt = CFG_W'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= XW'(RST_WIDTH + 2 * BORDER - 1);
            r_row_last <= ROW_W'(256 + 2 * BORDER - 1);
            r_x        <= '0;
            r_y        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_col_last <= XW'(32'(w_wid) + 2 * BORDER - 1);
                end
                REG_IMAGE_HEIGHT: begin
                    r_row_last <= ROW_W'(32'(w_hgt) + 2 * BORDER - 1);
                end
                default: begin
                end
            endcase
            r_x <= '0;
            r_y <= '0;
        end else if (w_accept) begin
            if (r_x == r_col_last) begin
                r_x <= '0;
                r_y <= (r_y == r_row_last) ? '0 : r_y + ROW_W'(1);
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

    // ---- stage 1: input word and line store read ----
    logic             r_s1_v;
    logic             r_s1_prod;
    t_tag             r_s1_tag;
    logic [PIX_W-1:0] r_s1_pix;
    logic [XW-1:0]    r_s1_x;
    logic [LINES*PIX_W-1:0] w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix           <= i_pixel_in;
            r_s1_x             <= r_x;
            r_s1_prod          <= (r_x >= XW'(2 * BORDER)) && (r_y >= ROW_W'(2 * BORDER));
            r_s1_tag.row_end   <= (r_x == r_col_last);
            r_s1_tag.frame_end <= (r_x == r_col_last) && (r_y == r_row_last);
        end
    end

    gbw_line_buf #(
        .DEPTH (LINE_LEN)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_x),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1_v && w_adv),
        .i_wr_addr (r_s1_x),
        .i_wr_data ({r_s1_pix, w_rd_data[LINES*PIX_W-1:PIX_W]})
    );

    // ---- window: chain of column cells, newest column enters the last cell ----
    logic              w_shift;
    t_col              w_col_in [KSIZE+1];
    logic [CSUM_W-1:0] w_csum [KSIZE];

    assign w_shift         = r_s1_v && w_adv;
    assign w_col_in[KSIZE] = t_col'({r_s1_pix, w_rd_data});

    for (genvar c = 0; c < KSIZE; c++) begin : g_cell
        gbw_col_cell #(
            .COL (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_adv   (w_adv),
            .i_col   (w_col_in[c+1]),
            .o_col   (w_col_in[c]),
            .o_csum  (w_csum[c])
        );
    end

    logic [PIX_W-1:0] w_norm_pix;

    gbw_norm u_norm (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_csum  (w_csum),
        .o_pixel (w_norm_pix)
    );

    // ---- result tracking: window, column sums, total, product ----
    logic [3:0] r_v;
    t_tag       r_tag [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            o_res_valid <= 1'b0;
        end else if (w_adv) begin
            r_v         <= {r_v[2:0], r_s1_v && r_s1_prod};
            o_res_valid <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag[0]    <= r_s1_tag;
            r_tag[1]    <= r_tag[0];
            r_tag[2]    <= r_tag[1];
            r_tag[3]    <= r_tag[2];
            o_pixel_out <= w_norm_pix;
            o_row_end   <= r_tag[3].row_end;
            o_frame_end <= r_tag[3].frame_end;
        end
    end

endmodule

/* rtl/core/gbw_line_buf.sv */
// ----------------------------------------------------------------------------
// gbw_line_buf
// Four packed line stores, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbw_line_buf #(
    parameter int DEPTH = 1028,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rd_en,
    input  logic [AW-1:0]                          i_rd_addr,
    output logic [gbw_pkg::LINES*gbw_pkg::PIX_W-1:0] o_rd_data,
    input  logic                                   i_wr_en,
    input  logic [AW-1:0]                          i_wr_addr,
    input  logic [gbw_pkg::LINES*gbw_pkg::PIX_W-1:0] i_wr_data
);
    import gbw_pkg::*;

    logic [LINES*PIX_W-1:0] r_mem [DEPTH];
    logic [LINES*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/gbw_col_cell.sv */
// ----------------------------------------------------------------------------
// gbw_col_cell
// One window column: holds five pixels, passes them on, registers the
// kernel-weighted column sum.
// ----------------------------------------------------------------------------
module gbw_col_cell #(
    parameter int COL = 0
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic                        i_adv,
    input  gbw_pkg::t_col               i_col,
    output gbw_pkg::t_col               o_col,
    output logic [gbw_pkg::CSUM_W-1:0]  o_csum
);
    import gbw_pkg::*;

    t_col              r_col;
    logic [CSUM_W-1:0] r_csum;
    logic [CSUM_W-1:0] n_csum;

    always_comb begin
        n_csum = '0;
        for (int r = 0; r < KSIZE; r++) begin
            n_csum = n_csum + CSUM_W'(r_col[r]) * CSUM_W'(KERNEL[r][COL]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
        if (i_adv) begin
            r_csum <= n_csum;
        end
    end

    assign o_col  = r_col;
    assign o_csum = r_csum;

endmodule

/* rtl/core/gbw_norm.sv */
// ----------------------------------------------------------------------------
// gbw_norm
// Adds the five column sums, divides by 273 and clamps to 255.
// ----------------------------------------------------------------------------
module gbw_norm (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  logic [gbw_pkg::CSUM_W-1:0]  i_csum [gbw_pkg::KSIZE],
    output logic [gbw_pkg::PIX_W-1:0]   o_pixel
);
    import gbw_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] r_prod;
    logic [QUOT_W-1:0] w_quot;

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < KSIZE; c++) begin
            n_sum = n_sum + SUM_W'(i_csum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum  <= n_sum;
            r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
        end
    end

    assign w_quot  = r_prod[PROD_W-1:DIV_SHIFT];
    assign o_pixel = (w_quot > QUOT_W'(255)) ? PIX_W'(255) : w_quot[PIX_W-1:0];

endmodule
